### src/att_pkg.sv
// Shared types and constants for the assembly text tokenizer.
// Used by the channel interfaces and the tokenizer top level.
package att_pkg;

   localparam int COLUMN_BITS = 12;
   localparam int ROW_BITS    = 16;

   localparam int CH_W   = 8;
   localparam int ROW_W  = 16;
   localparam int COL_W  = 12;
   localparam int LEN_W  = 12;

   localparam int TOK_MAX   = 5;
   localparam int TOK_IDX_W = $clog2(TOK_MAX);
   localparam int TOK_CNT_W = $clog2(TOK_MAX + 1);

   typedef enum logic [3:0] {
      K_LPAREN  = 4'd0,
      K_RPAREN  = 4'd1,
      K_STAR    = 4'd2,
      K_SIGN    = 4'd3,
      K_COMMA   = 4'd4,
      K_COLON   = 4'd5,
      K_CHARS   = 4'd6,
      K_DQUOTE  = 4'd7,
      K_INTEGER = 4'd8,
      K_NAME    = 4'd9,
      K_INVALID = 4'd10,
      K_EOL     = 4'd11
   } kind_type;

   typedef enum logic {
      FUNC_CHAR = 1'b0,
      FUNC_EOL  = 1'b1
   } func_type;

   localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

   typedef struct packed {
      kind_type          kind;
      logic [COL_W-1:0]  column;
      logic [LEN_W-1:0]  length;
      logic [CH_W-1:0]   first_char;
   } tok_type;

endpackage

### src/att_if.sv
// Valid/ready channel interfaces for the assembly text tokenizer.
// Depends on att_pkg for field widths and the token kind type.
interface att_req_if;
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [att_pkg::CH_W-1:0] ch;

   modport source (output valid, func, ch, input ready);
   modport sink   (input valid, func, ch, output ready);
endinterface

interface att_rsp_if;
   logic                      valid;
   logic                      ready;
   att_pkg::kind_type         kind;
   logic [att_pkg::ROW_W-1:0] row;
   logic [att_pkg::COL_W-1:0] column;
   logic [att_pkg::LEN_W-1:0] length;
   logic [att_pkg::CH_W-1:0]  first_char;
   logic                      last;

   modport source (output valid, kind, row, column, length, first_char, last, input ready);
   modport sink   (input valid, kind, row, column, length, first_char, last, output ready);
endinterface

### src/assembly_text_tokenizer.sv
// Assembly text tokenizer: streaming lexer over characters and end-of-line beats.
// Depends on att_pkg and the att_req_if / att_rsp_if channel interfaces.
//
// Usage:
//   req carries one beat per source character (func = 0, ch = byte) or one
//   end-of-line beat (func = 1). rsp carries tokens with kind, row, column,
//   length and first character; last marks the final token of a request beat.
//   A character is classified once two more characters of its line are in the
//   two-entry lookahead buffer, or when the line ends, so tokens lag the input
//   by two characters within a line.
//   Latency: the tokens of an accepted beat appear on rsp in the next cycle.
//   Throughput: one request beat per cycle while rsp is ready and each beat
//   yields at most one token; a beat yielding more tokens holds req until
//   they drain through the single token drain port of the five-entry result
//   buffer. An end-of-line beat yields one to four tokens.
//   Reset: synchronous, clears the lookahead buffer, scan mode and column, and
//   sets the row to one; the result buffer starts empty.
//   Stall: while rsp is not ready the current token holds; req is taken again
//   in the cycle the last buffered token is taken.
module assembly_text_tokenizer (
   input  logic           clock,
   input  logic           reset,
   att_req_if.sink        req,
   att_rsp_if.source      rsp
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_INT,
      MODE_NAME,
      MODE_COMMENT
   } mode_type;

   typedef struct packed {
      mode_type                          mode;
      logic [att_pkg::COLUMN_BITS-1:0]   run_start;
      logic [att_pkg::CH_W-1:0]          run_first;
      logic [att_pkg::COLUMN_BITS-1:0]   col;
   } scan_type;

   typedef struct packed {
      scan_type          s;
      logic [1:0]        n;
      att_pkg::tok_type  tok0;
      att_pkg::tok_type  tok1;
   } step_type;

   function automatic logic is_digit(logic [att_pkg::CH_W-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(logic [att_pkg::CH_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_xdigit(logic [att_pkg::CH_W-1:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_space(logic [att_pkg::CH_W-1:0] c);
      return c == att_pkg::CH_SPACE || (c >= att_pkg::CH_TAB && c <= att_pkg::CH_CR);
   endfunction

   function automatic att_pkg::tok_type run_token(scan_type s);
      att_pkg::tok_type t;
      logic [att_pkg::COLUMN_BITS-1:0] len;
      len = (s.col > s.run_start) ? s.col - s.run_start
                                  : att_pkg::COLUMN_BITS'(1);
      t.kind       = (s.mode == MODE_INT) ? att_pkg::K_INTEGER : att_pkg::K_NAME;
      t.column     = att_pkg::COL_W'(s.run_start);
      t.length     = att_pkg::LEN_W'(len);
      t.first_char = s.run_first;
      return t;
   endfunction

   function automatic step_type proc_char(scan_type s, logic [att_pkg::CH_W-1:0] c,
                                          logic two_follow);
      step_type         r;
      logic             cont;
      logic             pvalid;
      att_pkg::tok_type ptok;
      r      = '0;
      r.s    = s;
      pvalid = 1'b0;
      ptok.kind       = att_pkg::K_INVALID;
      ptok.column     = att_pkg::COL_W'(s.col);
      ptok.length     = att_pkg::LEN_W'(1);
      ptok.first_char = c;
      cont = (s.mode == MODE_COMMENT) || (s.mode == MODE_INT && is_xdigit(c)) ||
             (s.mode == MODE_NAME && (is_alpha(c) || is_digit(c)));
      if (!cont) begin
         if (s.mode == MODE_INT || s.mode == MODE_NAME) begin
            r.tok0   = run_token(s);
            r.n      = 2'd1;
            r.s.mode = MODE_IDLE;
         end
         pvalid = 1'b1;
         priority if (is_space(c)) begin
            pvalid = 1'b0;
         end else if (c == att_pkg::CH_SEMI) begin
            pvalid   = 1'b0;
            r.s.mode = MODE_COMMENT;
         end else if (c == att_pkg::CH_LPAREN) begin
            ptok.kind = att_pkg::K_LPAREN;
         end else if (c == att_pkg::CH_RPAREN) begin
            ptok.kind = att_pkg::K_RPAREN;
         end else if (c == att_pkg::CH_STAR) begin
            ptok.kind = att_pkg::K_STAR;
         end else if (c == att_pkg::CH_PLUS || c == att_pkg::CH_MINUS) begin
            ptok.kind = att_pkg::K_SIGN;
         end else if (c == att_pkg::CH_COMMA) begin
            ptok.kind = att_pkg::K_COMMA;
         end else if (c == att_pkg::CH_COLON) begin
            ptok.kind = att_pkg::K_COLON;
         end else if (c == att_pkg::CH_SQUOTE) begin
            if (two_follow) begin
               ptok.kind   = att_pkg::K_CHARS;
               ptok.length = att_pkg::LEN_W'(3);
            end
         end else if (c == att_pkg::CH_DQUOTE) begin
            ptok.kind = att_pkg::K_DQUOTE;
         end else if (is_digit(c)) begin
            pvalid        = 1'b0;
            r.s.mode      = MODE_INT;
            r.s.run_start = s.col;
            r.s.run_first = c;
         end else if (is_alpha(c)) begin
            pvalid        = 1'b0;
            r.s.mode      = MODE_NAME;
            r.s.run_start = s.col;
            r.s.run_first = c;
         end else begin
            ptok.kind = att_pkg::K_INVALID;
         end
      end
      if (pvalid) begin
         if (r.n == 2'd0) begin
            r.tok0 = ptok;
         end else begin
            r.tok1 = ptok;
         end
         r.n = r.n + 2'd1;
      end
      if (s.col != '1) begin
         r.s.col = s.col + att_pkg::COLUMN_BITS'(1);
      end
      return r;
   endfunction

   localparam int CAND_N = 6;

   mode_type                          mode_ff, mode_in;
   logic [att_pkg::COLUMN_BITS-1:0]   start_ff, start_in;
   logic [att_pkg::CH_W-1:0]          first_ff, first_in;
   logic [att_pkg::COLUMN_BITS-1:0]   col_ff, col_in;
   logic [att_pkg::ROW_BITS-1:0]      row_ff, row_in;
   logic [1:0]                        lav_ff, lav_in;
   logic [att_pkg::CH_W-1:0]          la_ff [2];
   logic [att_pkg::CH_W-1:0]          la_in [2];

   att_pkg::tok_type                  tok_ff [att_pkg::TOK_MAX];
   att_pkg::tok_type                  tok_in [att_pkg::TOK_MAX];
   logic [att_pkg::TOK_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [att_pkg::TOK_IDX_W-1:0]     head_ff;
   logic [att_pkg::ROW_W-1:0]         orow_ff;

   logic                              req_fire;
   logic                              rsp_fire;
   logic                              rsp_last;
   scan_type                          s_cur;
   scan_type                          s_end;
   step_type                          ra, rb;
   att_pkg::tok_type                  cand [CAND_N];
   logic [CAND_N-1:0]                 cvld;

   assign s_cur    = '{mode: mode_ff, run_start: start_ff, run_first: first_ff, col: col_ff};
   assign rsp.valid = att_pkg::TOK_CNT_W'(head_ff) < cnt_ff;
   assign rsp_last  = att_pkg::TOK_CNT_W'(head_ff) == cnt_ff - att_pkg::TOK_CNT_W'(1);
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign req.ready = !rsp.valid || (rsp_last && rsp.ready);
   assign req_fire  = req.valid && req.ready;

   assign rsp.kind       = tok_ff[head_ff].kind;
   assign rsp.column     = tok_ff[head_ff].column;
   assign rsp.length     = tok_ff[head_ff].length;
   assign rsp.first_char = tok_ff[head_ff].first_char;
   assign rsp.row        = orow_ff;
   assign rsp.last       = rsp_last;

   always_comb begin
      ra = '0;
      rb = '0;
      ra.s = s_cur;
      if (req.func == att_pkg::FUNC_CHAR) begin
         if (lav_ff == 2'd2) begin
            ra = proc_char(s_cur, la_ff[0], 1'b1);
         end
         rb.s = ra.s;
      end else begin
         if (lav_ff != 2'd0) begin
            ra = proc_char(s_cur, la_ff[0], 1'b0);
         end
         rb.s = ra.s;
         if (lav_ff == 2'd2) begin
            rb = proc_char(ra.s, la_ff[1], 1'b0);
         end
      end
      s_end = rb.s;
   end

   always_comb begin
      logic [att_pkg::TOK_CNT_W-1:0] n;
      att_pkg::tok_type              eol_tok;
      n = '0;
      eol_tok.kind       = att_pkg::K_EOL;
      eol_tok.column     = att_pkg::COL_W'(s_end.col);
      eol_tok.length     = att_pkg::LEN_W'(1);
      eol_tok.first_char = '0;
      cand[0] = ra.tok0;
      cand[1] = ra.tok1;
      cand[2] = rb.tok0;
      cand[3] = rb.tok1;
      cand[4] = run_token(s_end);
      cand[5] = eol_tok;
      cvld[0] = ra.n >= 2'd1;
      cvld[1] = ra.n >= 2'd2;
      cvld[2] = rb.n >= 2'd1;
      cvld[3] = rb.n >= 2'd2;
      cvld[4] = (req.func == att_pkg::FUNC_EOL) &&
                (s_end.mode == MODE_INT || s_end.mode == MODE_NAME);
      cvld[5] = req.func == att_pkg::FUNC_EOL;
      for (int i = 0; i < att_pkg::TOK_MAX; i++) begin
         tok_in[i] = tok_ff[i];
      end
      for (int i = 0; i < CAND_N; i++) begin
         if (cvld[i] && n < att_pkg::TOK_CNT_W'(att_pkg::TOK_MAX)) begin
            tok_in[n[att_pkg::TOK_IDX_W-1:0]] = cand[i];
            n = n + att_pkg::TOK_CNT_W'(1);
         end
      end
      cnt_in = n;
   end

   always_comb begin
      mode_in  = s_end.mode;
      start_in = s_end.run_start;
      first_in = s_end.run_first;
      col_in   = s_end.col;
      row_in   = row_ff;
      lav_in   = lav_ff;
      la_in[0] = la_ff[0];
      la_in[1] = la_ff[1];
      if (req.func == att_pkg::FUNC_CHAR) begin
         unique case (lav_ff)
            2'd0: begin
               la_in[0] = req.ch;
               lav_in   = 2'd1;
            end
            2'd1: begin
               la_in[1] = req.ch;
               lav_in   = 2'd2;
            end
            default: begin
               la_in[0] = la_ff[1];
               la_in[1] = req.ch;
            end
         endcase
      end else begin
         la_in[0] = '0;
         la_in[1] = '0;
         lav_in   = 2'd0;
         mode_in  = MODE_IDLE;
         col_in   = '0;
         if (row_ff != '1) begin
            row_in = row_ff + att_pkg::ROW_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         col_ff  <= '0;
         row_ff  <= att_pkg::ROW_BITS'(1);
         lav_ff  <= 2'd0;
         cnt_ff  <= '0;
         head_ff <= '0;
      end else if (req_fire) begin
         mode_ff <= mode_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         lav_ff  <= lav_in;
         cnt_ff  <= cnt_in;
         head_ff <= '0;
      end else if (rsp_fire) begin
         head_ff <= head_ff + att_pkg::TOK_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_ff <= start_in;
         first_ff <= first_in;
         la_ff[0] <= la_in[0];
         la_ff[1] <= la_in[1];
         orow_ff  <= att_pkg::ROW_W'(row_ff);
         for (int i = 0; i < att_pkg::TOK_MAX; i++) begin
            tok_ff[i] <= tok_in[i];
         end
      end
   end

   a_eol_gives_token: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.func |=> rsp.valid)
      else $error("end-of-line beat produced no token");

   a_eol_clears_line: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.func |=> lav_ff == 2'd0 && col_ff == '0)
      else $error("line state not cleared after end of line");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= att_pkg::TOK_CNT_W'(att_pkg::TOK_MAX))
      else $error("result buffer count out of range");

   a_char_row_hold: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && !req.func |=> $stable(row_ff))
      else $error("row changed on a character beat");

   a_char_single_token: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && !req.func |=> cnt_ff <= att_pkg::TOK_CNT_W'(2))
      else $error("character beat produced too many tokens");

endmodule
